FILE: rtl/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg: shared types, constants and helpers of the radix digit emitter
// Holds field widths, character codes, configuration register indexes and
// the symbol lookup used by both the top level and the base checker.
// ----------------------------------------------------------------------------
package srde_pkg;

    // Field and register widths.
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int SYM_SLOTS   = 16;
    localparam int ALPHA_W     = SYM_SLOTS * CHAR_W;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Defaults for the top-level parameters.
    localparam int MAX_SYMBOLS_DEF       = 16;
    localparam int DIGIT_STORE_DEPTH_DEF = 32;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHABET_LOW    = 2'd0,
        REG_ALPHABET_HIGH   = 2'd1,
        REG_ALPHABET_LENGTH = 2'd2
    } cfg_reg_t;

    // Result of one alphabet check.
    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    // Symbol k of the packed alphabet, symbol 0 in the lowest byte.
    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [ALPHA_W-1:0] alphabet,
        input logic [DIGIT_W-1:0] k
    );
        return alphabet[k*CHAR_W +: CHAR_W];
    endfunction

    // True for a byte that may not serve as a digit symbol.
    function automatic logic symbol_reserved(input logic [CHAR_W-1:0] s);
        return (s == CHAR_MINUS) || (s == CHAR_PLUS) || (s == CHAR_SPACE) ||
               (s == CHAR_NUL);
    endfunction

endpackage

FILE: rtl/signed_radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit: signed integer to text in any radix
// Writes a signed 32-bit value as a string of symbols from a programmable
// alphabet, using a bit-serial divider and a small digit memory.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes the alphabet (index 0: symbols 0-7, index 1:
//   symbols 8-15, index 2: length, which is the radix); write it only while
//   the unit is idle. Each word on s_axis carries one value. The m_axis side
//   returns one word per character: an optional '-', then the digits, most
//   significant first, with tlast on the final one. A bad alphabet yields a
//   single word with tuser set, tdata zero and tlast set.
//   Sequence: the alphabet check runs first. Each digit then comes from the
//   shift-and-subtract divider, one quotient bit per cycle, and each
//   character is fetched through the digit memory read port. Radix 2 and a
//   32-digit magnitude is the worst case.
//   One value is in work at a time; s_axis_tready is high while idle, also
//   while the last word still waits in the output register.
//   A stall on m_axis holds the output word and pauses the emit sequence.
//   Reset empties the output register and clears the alphabet registers.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_unit #(
    parameter int MAX_SYMBOLS       = srde_pkg::MAX_SYMBOLS_DEF,
    parameter int DIGIT_STORE_DEPTH = srde_pkg::DIGIT_STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream. tdata: value[31:0].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [srde_pkg::VALUE_W-1:0]     s_axis_tdata,
    // Output stream. tdata: character[7:0]; tuser: base_invalid[0].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [srde_pkg::CHAR_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic [0:0]                       m_axis_tuser,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srde_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srde_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srde_pkg::*;

    localparam int AW      = $clog2(DIGIT_STORE_DEPTH);
    localparam int CW      = $clog2(DIGIT_STORE_DEPTH + 1);
    localparam int BW      = $clog2(VALUE_W);
    localparam int BIT_TOP = VALUE_W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ERROR,
        S_ZERO,
        S_DIVIDE,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] alphabet_low_reg;
    logic [CFG_DATA_W-1:0] alphabet_high_reg;
    logic [RADIX_W-1:0]    alphabet_length_reg;
    logic [ALPHA_W-1:0]    alphabet;

    // Control and datapath registers.
    state_t               state_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 neg_reg;
    logic [VALUE_W-1:0]   div_mag_reg;
    logic [DIGIT_W-1:0]   div_rem_reg;
    logic [BW-1:0]        bit_cnt_reg;
    logic [CW-1:0]        count_reg;
    logic [DIGIT_W-1:0]   rd_digit_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;

    // Digit memory, no reset: every entry read was written for this value.
    logic [DIGIT_W-1:0]   digit_mem [DIGIT_STORE_DEPTH];

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic [RADIX_W-1:0]   rem_shift;
    logic                 qbit;
    logic [RADIX_W-1:0]   rem_sub;
    logic [DIGIT_W-1:0]   rem_next;
    logic [VALUE_W-1:0]   mag_next;
    logic                 digit_done;
    logic [CW-1:0]        count_dec;
    chk_status_t          chk_status;

    assign alphabet  = {alphabet_high_reg, alphabet_low_reg};
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_low_reg    <= '0;
            alphabet_high_reg   <= '0;
            alphabet_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALPHABET_LOW:    alphabet_low_reg    <= cfg_data;
                REG_ALPHABET_HIGH:   alphabet_high_reg   <= cfg_data;
                REG_ALPHABET_LENGTH: alphabet_length_reg <= cfg_data[RADIX_W-1:0];
                default:             ;
            endcase
        end
    end

    // Alphabet validity checker, started on each accepted value.
    srde_base_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_base_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .alphabet (alphabet),
        .length   (alphabet_length_reg),
        .status   (chk_status)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // A new word enters the output register in this cycle.
    assign out_load = out_free && (state_reg inside {S_ERROR, S_ZERO, S_SIGN, S_EMIT});

    // One restoring division step: shift in the next dividend bit.
    assign rem_shift  = {div_rem_reg, div_mag_reg[VALUE_W-1]};
    assign qbit       = (rem_shift >= alphabet_length_reg);
    assign rem_sub    = rem_shift - alphabet_length_reg;
    assign rem_next   = qbit ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
    assign mag_next   = {div_mag_reg[VALUE_W-2:0], qbit};
    assign digit_done = (state_reg == S_DIVIDE) && (bit_cnt_reg == BW'(BIT_TOP));
    assign count_dec  = count_reg - CW'(1);

    // Digit memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_mem[count_reg[AW-1:0]] <= rem_next;
        end
        if (state_reg == S_READ)
        begin
            rd_digit_reg <= digit_mem[count_dec[AW-1:0]];
        end
    end

    // Main sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            value_reg     <= '0;
            neg_reg       <= 1'b0;
            div_mag_reg   <= '0;
            div_rem_reg   <= '0;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        value_reg <= s_axis_tdata;
                        neg_reg   <= s_axis_tdata[VALUE_W-1];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (chk_status.done)
                    begin
                        if (!chk_status.ok)
                        begin
                            state_reg <= S_ERROR;
                        end
                        else if (value_reg == '0)
                        begin
                            state_reg <= S_ZERO;
                        end
                        else
                        begin
                            div_mag_reg <= neg_reg ? (VALUE_W'(0) - value_reg) : value_reg;
                            div_rem_reg <= '0;
                            bit_cnt_reg <= '0;
                            count_reg   <= '0;
                            state_reg   <= S_DIVIDE;
                        end
                    end
                end
                S_ERROR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= CHAR_NUL;
                        out_last_reg  <= 1'b1;
                        out_err_reg   <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_ZERO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= symbol_at(alphabet, DIGIT_W'(0));
                        out_last_reg  <= 1'b1;
                        out_err_reg   <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIVIDE:
                begin
                    div_mag_reg <= mag_next;
                    if (digit_done)
                    begin
                        // Remainder goes to the digit memory; restart on the quotient.
                        count_reg   <= count_reg + CW'(1);
                        div_rem_reg <= '0;
                        bit_cnt_reg <= '0;
                        if (mag_next == '0)
                        begin
                            state_reg <= neg_reg ? S_SIGN : S_READ;
                        end
                    end
                    else
                    begin
                        div_rem_reg <= rem_next;
                        bit_cnt_reg <= bit_cnt_reg + BW'(1);
                    end
                end
                S_SIGN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= CHAR_MINUS;
                        out_last_reg  <= 1'b0;
                        out_err_reg   <= 1'b0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    count_reg <= count_dec;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= symbol_at(alphabet, rd_digit_reg);
                        out_last_reg  <= (count_reg == '0);
                        out_err_reg   <= 1'b0;
                        state_reg     <= (count_reg == '0) ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_char_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_err_reg;

    // An error word is a lone, zero, final word.
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == CHAR_NUL)))
        else $error("error word without tlast or with nonzero data");

    // The partial remainder always stays below the radix.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> ({1'b0, div_rem_reg} < alphabet_length_reg))
        else $error("divider remainder out of range");

    // The digit count never runs past the memory.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DIGIT_STORE_DEPTH))
        else $error("digit count beyond memory depth");

    // The checker only reports while the sequencer waits for it.
    a_check_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        chk_status.done |-> (state_reg == S_CHECK))
        else $error("alphabet check finished outside the check state");

    // An accepted value always starts an alphabet check.
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_CHECK))
        else $error("accepted value did not start a check");

endmodule

FILE: rtl/srde_base_check.sv
// ----------------------------------------------------------------------------
// srde_base_check: sequential validity check of the digit alphabet
// Walks the symbols in use one per cycle, testing each against the reserved
// bytes and, in parallel lanes, against every later symbol in use.
// ----------------------------------------------------------------------------
module srde_base_check #(
    parameter int MAX_SYMBOLS = srde_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [srde_pkg::ALPHA_W-1:0] alphabet,
    input  logic [srde_pkg::RADIX_W-1:0] length,
    output srde_pkg::chk_status_t        status
);
    import srde_pkg::*;

    localparam int IW = $clog2(MAX_SYMBOLS);

    typedef enum logic {
        CK_IDLE,
        CK_RUN
    } ck_state_t;

    ck_state_t         state_reg;
    logic [IW-1:0]     idx_reg;
    logic              fail_reg;
    logic              done_reg;
    logic              ok_reg;
    logic              length_bad;
    logic [CHAR_W-1:0] cur_sym;
    logic              dup;
    logic              is_last;

    // Length must give a radix of at least two and fit the symbol lanes.
    assign length_bad = (length < RADIX_W'(2)) || (length > RADIX_W'(MAX_SYMBOLS));

    assign cur_sym = symbol_at(alphabet, DIGIT_W'(idx_reg));

    // Compare the current symbol against every later symbol in use.
    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((j > int'(idx_reg)) && (RADIX_W'(j) < length) &&
                (symbol_at(alphabet, DIGIT_W'(j)) == cur_sym))
            begin
                dup = 1'b1;
            end
        end
    end

    assign is_last = ((RADIX_W'(idx_reg) + RADIX_W'(1)) >= length) ||
                     (idx_reg == IW'(MAX_SYMBOLS - 1));

    // Check sequencer with registered status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CK_IDLE;
            idx_reg   <= '0;
            fail_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                CK_IDLE:
                begin
                    if (start)
                    begin
                        fail_reg  <= length_bad;
                        idx_reg   <= '0;
                        state_reg <= CK_RUN;
                    end
                end
                CK_RUN:
                begin
                    if (fail_reg)
                    begin
                        done_reg  <= 1'b1;
                        ok_reg    <= 1'b0;
                        state_reg <= CK_IDLE;
                    end
                    else if (symbol_reserved(cur_sym) || dup)
                    begin
                        fail_reg <= 1'b1;
                    end
                    else if (is_last)
                    begin
                        done_reg  <= 1'b1;
                        ok_reg    <= 1'b1;
                        state_reg <= CK_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                default:
                begin
                    state_reg <= CK_IDLE;
                end
            endcase
        end
    end

    assign status = '{done: done_reg, ok: ok_reg};

endmodule
